/* design/wdt_pkg.sv */
// Shared types, register map and constants for the watchdog timer register block.
`timescale 1ns / 1ps

package wdt_pkg;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;

    localparam logic [11:0] OFS_LOAD   = 12'h000;
    localparam logic [11:0] OFS_VALUE  = 12'h004;
    localparam logic [11:0] OFS_CTRL   = 12'h008;
    localparam logic [11:0] OFS_INTCLR = 12'h00C;
    localparam logic [11:0] OFS_RIS    = 12'h010;
    localparam logic [11:0] OFS_MIS    = 12'h014;
    localparam logic [11:0] OFS_LOCK   = 12'hC00;
    localparam logic [11:0] OFS_ID     = 12'hFE0;

    localparam logic [31:0] KEY_UNLOCK = 32'h1ACCE551;

    typedef struct packed {
        logic [1:0]  command;
        logic [11:0] offset;
        logic [31:0] write_data;
        logic [1:0]  access_size;
    } item_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        bad_offset;
        logic        irq_out;
        logic        reset_request;
    } result_t;

    function automatic logic [7:0] id_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h05;
            3'd1:    b = 8'h18;
            3'd2:    b = 8'h14;
            3'd3:    b = 8'h00;
            3'd4:    b = 8'h0D;
            3'd5:    b = 8'hF0;
            3'd6:    b = 8'h05;
            3'd7:    b = 8'hB1;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

/* design/watchdog_timer_registers_unit.sv */
// Top level of the watchdog timer register block: stream ports, input and result registers.
`timescale 1ns / 1ps

// Flow: a transaction accepted from the stream sits in the input register, and its result
// enters the result register, raising m_axis_tvalid, when that register is free to take it.
// Throughput: one transaction per cycle while m_axis_tready keeps the result register free.
// Reset: rst_n clears both valid flags, the counter and load to all ones, control,
// pending interrupt and lock to zero.

module watchdog_timer_registers_unit #(
    parameter int COUNTER_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // offset[11:0], write_data[43:12], access_size[45:44]
    input  logic [1:0]  s_axis_tuser,  // command[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata   // read_data[31:0], bad_offset[32], irq_out[33],
                                       // reset_request[34]
);

    logic             in_valid_reg;
    wdt_pkg::item_t   in_item_reg;
    logic             out_valid_reg;
    wdt_pkg::result_t out_result_reg;
    wdt_pkg::result_t result;
    logic             out_free;
    logic             advance;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_item_reg.command     <= s_axis_tuser;
            in_item_reg.offset      <= s_axis_tdata[11:0];
            in_item_reg.write_data  <= s_axis_tdata[43:12];
            in_item_reg.access_size <= s_axis_tdata[45:44];
        end
    end

    wdt_core #(
        .COUNTER_WIDTH(COUNTER_WIDTH)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (in_item_reg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_result_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_result_reg.reset_request, out_result_reg.irq_out,
                            out_result_reg.bad_offset, out_result_reg.read_data};

endmodule

/* design/wdt_core.sv */
// Watchdog state registers with the per-transaction register access and countdown logic.
`timescale 1ns / 1ps

module wdt_core #(
    parameter int COUNTER_WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  wdt_pkg::item_t   item,
    output wdt_pkg::result_t result
);

    logic [COUNTER_WIDTH-1:0] load_reg;
    logic [COUNTER_WIDTH-1:0] load_next;
    logic [COUNTER_WIDTH-1:0] count_reg;
    logic [COUNTER_WIDTH-1:0] count_next;
    logic [1:0]               ctrl_reg;
    logic [1:0]               ctrl_next;
    logic                     pending_reg;
    logic                     pending_next;
    logic                     locked_reg;
    logic                     locked_next;

    logic [11:0] word;
    logic        hit;
    logic [31:0] cur;
    logic [4:0]  shift;
    logic [31:0] mask;
    logic [31:0] lanes;
    logic [31:0] merged;
    logic        is_word;
    logic [31:0] rdata;
    logic        bad;
    logic        rst_req;

    assign word = {item.offset[11:2], 2'b00};

    always_comb
    begin
        hit = 1'b1;
        cur = 32'd0;
        if (word >= wdt_pkg::OFS_ID)
        begin
            cur = {24'd0, wdt_pkg::id_byte(word[4:2])};
        end
        else
        begin
            case (word)
                wdt_pkg::OFS_LOAD:   cur = 32'(load_reg);
                wdt_pkg::OFS_VALUE:  cur = 32'(count_reg);
                wdt_pkg::OFS_CTRL:   cur = {30'd0, ctrl_reg};
                wdt_pkg::OFS_INTCLR: cur = 32'd0;
                wdt_pkg::OFS_RIS:    cur = {31'd0, pending_reg};
                wdt_pkg::OFS_MIS:    cur = {31'd0, pending_reg & ctrl_reg[0]};
                wdt_pkg::OFS_LOCK:   cur = {31'd0, locked_reg};
                default:             hit = 1'b0;
            endcase
        end
    end

    always_comb
    begin
        is_word = 1'b0;
        case (item.access_size)
            wdt_pkg::SIZE_BYTE:
            begin
                shift = {item.offset[1:0], 3'b000};
                mask  = 32'h0000_00FF;
            end
            wdt_pkg::SIZE_HALF:
            begin
                shift = {item.offset[1], 4'b0000};
                mask  = 32'h0000_FFFF;
            end
            default:
            begin
                shift   = 5'd0;
                mask    = 32'hFFFF_FFFF;
                is_word = 1'b1;
            end
        endcase
    end

    assign lanes  = mask << shift;
    assign merged = (cur & ~lanes) | (item.write_data & lanes);

    always_comb
    begin
        load_next    = load_reg;
        count_next   = count_reg;
        ctrl_next    = ctrl_reg;
        pending_next = pending_reg;
        locked_next  = locked_reg;
        rdata        = 32'd0;
        bad          = 1'b0;
        rst_req      = 1'b0;
        case (item.command)
            wdt_pkg::CMD_TICK:
            begin
                if (ctrl_reg[0])
                begin
                    if (count_reg == '0)
                    begin
                        if (pending_reg)
                        begin
                            rst_req = ctrl_reg[1];
                        end
                        else
                        begin
                            pending_next = 1'b1;
                        end
                        count_next = load_reg;
                    end
                    else
                    begin
                        count_next = count_reg - {{(COUNTER_WIDTH-1){1'b0}}, 1'b1};
                    end
                end
            end
            wdt_pkg::CMD_READ:
            begin
                if (!hit)
                begin
                    bad = 1'b1;
                end
                else
                begin
                    rdata = (cur >> shift) & mask;
                end
            end
            wdt_pkg::CMD_WRITE:
            begin
                if (!hit)
                begin
                    bad = 1'b1;
                end
                else if (word == wdt_pkg::OFS_LOCK)
                begin
                    if (is_word)
                    begin
                        locked_next = (item.write_data != wdt_pkg::KEY_UNLOCK);
                    end
                end
                else if (!locked_reg)
                begin
                    if (word == wdt_pkg::OFS_LOAD)
                    begin
                        load_next  = merged[COUNTER_WIDTH-1:0];
                        count_next = merged[COUNTER_WIDTH-1:0];
                    end
                    else if (word == wdt_pkg::OFS_CTRL)
                    begin
                        if (merged[0] && !ctrl_reg[0])
                        begin
                            count_next = load_reg;
                        end
                        ctrl_next = merged[1:0];
                    end
                    else if (word == wdt_pkg::OFS_INTCLR)
                    begin
                        if (pending_reg)
                        begin
                            pending_next = 1'b0;
                            count_next   = load_reg;
                        end
                    end
                end
            end
            default:
            begin
                bad = 1'b0;
            end
        endcase
    end

    assign result.read_data     = rdata;
    assign result.bad_offset    = bad;
    assign result.irq_out       = pending_next & ctrl_next[0];
    assign result.reset_request = rst_req;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_reg    <= '1;
            count_reg   <= '1;
            ctrl_reg    <= 2'b00;
            pending_reg <= 1'b0;
            locked_reg  <= 1'b0;
        end
        else if (step)
        begin
            load_reg    <= load_next;
            count_reg   <= count_next;
            ctrl_reg    <= ctrl_next;
            pending_reg <= pending_next;
            locked_reg  <= locked_next;
        end
    end

endmodule

/* sim/tb_watchdog_timer_registers_unit.sv */
// Self-checking testbench for the watchdog timer register block with a built-in predictor.
`timescale 1ns / 1ps

module tb_watchdog_timer_registers_unit;

    localparam int          CNT_W      = 32;
    localparam logic [31:0] CNT_MASK   = 32'hFFFF_FFFF >> (32 - CNT_W);
    localparam logic [1:0]  CMD_NONE   = 2'd3;
    localparam logic [1:0]  SIZE_WORD  = 2'd2;
    localparam logic [1:0]  SIZE_WIDE  = 2'd3;
    localparam logic [11:0] OFS_HOLE   = 12'h018;
    localparam logic [11:0] OFS_FAR    = 12'h800;
    localparam int          CYCLE_CAP  = 200000;
    localparam int          TAIL_WAIT  = 8;
    localparam int          SHOW_CAP   = 100;

    localparam logic [7:0]  ID_TABLE [8] = '{8'h05, 8'h18, 8'h14, 8'h00,
                                             8'h0D, 8'hF0, 8'h05, 8'hB1};
    localparam logic [11:0] REG_MAP [8]  = '{wdt_pkg::OFS_LOAD, wdt_pkg::OFS_VALUE,
                                             wdt_pkg::OFS_CTRL, wdt_pkg::OFS_INTCLR,
                                             wdt_pkg::OFS_RIS, wdt_pkg::OFS_MIS,
                                             wdt_pkg::OFS_LOCK, wdt_pkg::OFS_ID};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;   // offset[11:0], write_data[43:12], access_size[45:44]
    logic [1:0]  s_axis_tuser = '0;   // command[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;        // read_data[31:0], bad_offset[32], irq_out[33],
                                      // reset_request[34]

    // predictor state
    logic [31:0] load_reg;
    logic [31:0] count_reg;
    logic [1:0]  ctrl_reg;
    logic        pend_reg;
    logic        lock_reg;

    wdt_pkg::item_t   bus_ops [$];
    wdt_pkg::result_t awaited_responses [$];
    wdt_pkg::item_t   next_op;
    wdt_pkg::result_t seen;
    wdt_pkg::result_t want;
    int               burst_left;
    int               gap_left;
    int               stall_mode;
    int               mode_timer;
    int               cycle_count = 0;
    int               fault_count = 0;

    watchdog_timer_registers_unit #(
        .COUNTER_WIDTH (CNT_W)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic wdt_pkg::result_t advance_watchdog(input wdt_pkg::item_t op);
        wdt_pkg::result_t r;
        logic [11:0]      word;
        logic [11:0]      rel;
        logic [31:0]      cur;
        logic [31:0]      mask;
        logic [31:0]      lanes;
        logic [31:0]      merged;
        int               shift;
        logic             hit;
        r = '0;
        if (op.command == wdt_pkg::CMD_TICK)
        begin
            if (ctrl_reg[0])
            begin
                if (count_reg == 32'd0)
                begin
                    if (pend_reg)
                        r.reset_request = ctrl_reg[1];
                    else
                        pend_reg = 1'b1;
                    count_reg = load_reg;
                end
                else
                begin
                    count_reg = (count_reg - 32'd1) & CNT_MASK;
                end
            end
        end
        else if (op.command == wdt_pkg::CMD_READ || op.command == wdt_pkg::CMD_WRITE)
        begin
            word = {op.offset[11:2], 2'b00};
            rel  = word - wdt_pkg::OFS_ID;
            hit  = 1'b1;
            cur  = '0;
            if (word >= wdt_pkg::OFS_ID)
            begin
                cur = {24'd0, ID_TABLE[rel[4:2]]};
            end
            else
            begin
                case (word)
                    wdt_pkg::OFS_LOAD:   cur = load_reg;
                    wdt_pkg::OFS_VALUE:  cur = count_reg;
                    wdt_pkg::OFS_CTRL:   cur = {30'd0, ctrl_reg};
                    wdt_pkg::OFS_INTCLR: cur = '0;
                    wdt_pkg::OFS_RIS:    cur = {31'd0, pend_reg};
                    wdt_pkg::OFS_MIS:    cur = {31'd0, pend_reg & ctrl_reg[0]};
                    wdt_pkg::OFS_LOCK:   cur = {31'd0, lock_reg};
                    default:             hit = 1'b0;
                endcase
            end
            case (op.access_size)
                wdt_pkg::SIZE_BYTE:
                begin
                    shift = int'(op.offset[1:0]) * 8;
                    mask  = 32'h0000_00FF;
                end
                wdt_pkg::SIZE_HALF:
                begin
                    shift = int'(op.offset[1]) * 16;
                    mask  = 32'h0000_FFFF;
                end
                default:
                begin
                    shift = 0;
                    mask  = 32'hFFFF_FFFF;
                end
            endcase
            if (!hit)
            begin
                r.bad_offset = 1'b1;
            end
            else if (op.command == wdt_pkg::CMD_READ)
            begin
                r.read_data = (cur >> shift) & mask;
            end
            else if (word == wdt_pkg::OFS_LOCK)
            begin
                if (mask == 32'hFFFF_FFFF)
                    lock_reg = (op.write_data != wdt_pkg::KEY_UNLOCK);
            end
            else if (!lock_reg)
            begin
                lanes  = mask << shift;
                merged = (cur & ~lanes) | (op.write_data & lanes);
                if (word == wdt_pkg::OFS_LOAD)
                begin
                    load_reg  = merged & CNT_MASK;
                    count_reg = load_reg;
                end
                else if (word == wdt_pkg::OFS_CTRL)
                begin
                    if (merged[0] && !ctrl_reg[0])
                        count_reg = load_reg;
                    ctrl_reg = merged[1:0];
                end
                else if (word == wdt_pkg::OFS_INTCLR && pend_reg)
                begin
                    pend_reg  = 1'b0;
                    count_reg = load_reg;
                end
            end
        end
        r.irq_out = pend_reg & ctrl_reg[0];
        return r;
    endfunction

    function automatic wdt_pkg::item_t make_op(input logic [1:0] cmd, input logic [11:0] ofs,
                                               input logic [31:0] data,
                                               input logic [1:0] size);
        wdt_pkg::item_t op;
        op.command     = cmd;
        op.offset      = ofs;
        op.write_data  = data;
        op.access_size = size;
        return op;
    endfunction

    function automatic wdt_pkg::item_t random_op();
        wdt_pkg::item_t op;
        int unsigned    roll;
        logic [11:0]    word;
        roll = $urandom_range(0, 99);
        op.command = (roll < 45) ? wdt_pkg::CMD_TICK : (roll < 67) ? wdt_pkg::CMD_READ :
                     (roll < 97) ? wdt_pkg::CMD_WRITE : CMD_NONE;
        op.write_data = $urandom;
        if ($urandom_range(0, 9) < 7)
            op.access_size = ($urandom_range(0, 4) == 0) ? SIZE_WIDE : SIZE_WORD;
        else
            op.access_size = $urandom_range(0, 1) ? wdt_pkg::SIZE_HALF : wdt_pkg::SIZE_BYTE;
        roll = $urandom_range(0, 99);
        if (roll < 85)
        begin
            word = REG_MAP[$urandom_range(0, 7)];
            if (word == wdt_pkg::OFS_ID)
                word = word + {7'd0, 3'($urandom_range(0, 7)), 2'b00};
            op.offset = word | 12'($urandom_range(0, 3));
        end
        else if (roll < 95)
        begin
            op.offset = 12'($urandom);
            word      = {op.offset[11:2], 2'b00};
        end
        else
        begin
            op.offset = wdt_pkg::OFS_ID | 12'($urandom_range(0, 31));
            word      = {op.offset[11:2], 2'b00};
        end
        if (op.command == wdt_pkg::CMD_WRITE && word == wdt_pkg::OFS_LOAD
            && $urandom_range(0, 9) < 7)
        begin
            op.write_data  = $urandom_range(0, 12);
            op.access_size = SIZE_WORD;
        end
        if (op.command == wdt_pkg::CMD_WRITE && word == wdt_pkg::OFS_LOCK
            && $urandom_range(0, 9) < 8)
        begin
            op.access_size = SIZE_WORD;
            op.write_data  = ($urandom_range(0, 19) < 17) ? wdt_pkg::KEY_UNLOCK : $urandom;
        end
        return op;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (exp_val !== act_val)
        begin
            fault_count++;
            if (fault_count <= SHOW_CAP)
                $display("%0t ns: %s mismatch, expected 0x%08h, actual 0x%08h",
                         $time, name, exp_val, act_val);
        end
    endtask

    task automatic drain();
        while (bus_ops.size() != 0 || s_axis_tvalid || awaited_responses.size() != 0)
            @(negedge clk);
    endtask

    // sender: bursts of transactions separated by random gaps, some of them empty
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            burst_left    <= 0;
            gap_left      <= 0;
            load_reg      = CNT_MASK;
            count_reg     = CNT_MASK;
            ctrl_reg      = '0;
            pend_reg      = 1'b0;
            lock_reg      = 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                awaited_responses.push_back(advance_watchdog(make_op(s_axis_tuser,
                    s_axis_tdata[11:0], s_axis_tdata[43:12], s_axis_tdata[45:44])));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (gap_left != 0)
                begin
                    gap_left      <= gap_left - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (bus_ops.size() != 0)
                begin
                    next_op = bus_ops.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {2'b00, next_op.access_size, next_op.write_data,
                                      next_op.offset};
                    s_axis_tuser  <= next_op.command;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 30);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                    begin
                        burst_left <= burst_left - 1;
                    end
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: check each transaction and stall in changing modes
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_mode    <= 0;
            mode_timer    <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen.read_data     = m_axis_tdata[31:0];
                seen.bad_offset    = m_axis_tdata[32];
                seen.irq_out       = m_axis_tdata[33];
                seen.reset_request = m_axis_tdata[34];
                if (awaited_responses.size() == 0)
                begin
                    fault_count++;
                    if (fault_count <= SHOW_CAP)
                        $display("%0t ns: unexpected transaction, expected none, actual 0x%010h",
                                 $time, m_axis_tdata);
                end
                else
                begin
                    want = awaited_responses.pop_front();
                    check_field("read_data", want.read_data, seen.read_data);
                    check_field("bad_offset", 32'(want.bad_offset), 32'(seen.bad_offset));
                    check_field("irq_out", 32'(want.irq_out), 32'(seen.irq_out));
                    check_field("reset_request", 32'(want.reset_request),
                                32'(seen.reset_request));
                end
            end
            if (mode_timer == 0)
            begin
                stall_mode <= $urandom_range(0, 3);
                mode_timer <= $urandom_range(20, 120);
            end
            else
            begin
                mode_timer <= mode_timer - 1;
            end
            case (stall_mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
                2:       m_axis_tready <= (mode_timer[1:0] != 2'b00);
                default: m_axis_tready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("FAIL watchdog_timer_registers_unit");
            $finish;
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        bus_ops.push_back(make_op(wdt_pkg::CMD_READ, wdt_pkg::OFS_ID, '0, SIZE_WORD));
        bus_ops.push_back(make_op(wdt_pkg::CMD_READ, 12'hFFC, '0, wdt_pkg::SIZE_BYTE));
        bus_ops.push_back(make_op(wdt_pkg::CMD_READ, 12'hFE4, '0, wdt_pkg::SIZE_HALF));
        bus_ops.push_back(make_op(wdt_pkg::CMD_READ, wdt_pkg::OFS_LOAD, '0, SIZE_WIDE));
        bus_ops.push_back(make_op(wdt_pkg::CMD_READ, wdt_pkg::OFS_VALUE | 12'h2, '0,
                                  wdt_pkg::SIZE_HALF));
        bus_ops.push_back(make_op(wdt_pkg::CMD_READ, OFS_HOLE, '0, SIZE_WORD));
        bus_ops.push_back(make_op(wdt_pkg::CMD_WRITE, OFS_FAR, 32'hFFFF_FFFF, SIZE_WORD));
        bus_ops.push_back(make_op(wdt_pkg::CMD_WRITE, wdt_pkg::OFS_RIS, 32'hFFFF_FFFF,
                                  SIZE_WORD));
        bus_ops.push_back(make_op(wdt_pkg::CMD_WRITE, wdt_pkg::OFS_LOCK, '0, SIZE_WORD));
        bus_ops.push_back(make_op(wdt_pkg::CMD_WRITE, wdt_pkg::OFS_LOAD, 32'd1, SIZE_WORD));
        bus_ops.push_back(make_op(wdt_pkg::CMD_READ, wdt_pkg::OFS_LOCK, '0, SIZE_WORD));
        bus_ops.push_back(make_op(wdt_pkg::CMD_WRITE, wdt_pkg::OFS_LOCK, wdt_pkg::KEY_UNLOCK,
                                  wdt_pkg::SIZE_BYTE));
        bus_ops.push_back(make_op(wdt_pkg::CMD_WRITE, wdt_pkg::OFS_LOCK, wdt_pkg::KEY_UNLOCK,
                                  SIZE_WORD));
        bus_ops.push_back(make_op(wdt_pkg::CMD_WRITE, wdt_pkg::OFS_LOAD, 32'd1, SIZE_WORD));
        bus_ops.push_back(make_op(wdt_pkg::CMD_WRITE, wdt_pkg::OFS_CTRL, 32'd3, SIZE_WORD));
        repeat (4) bus_ops.push_back(make_op(wdt_pkg::CMD_TICK, '0, '0, wdt_pkg::SIZE_BYTE));
        bus_ops.push_back(make_op(wdt_pkg::CMD_READ, wdt_pkg::OFS_MIS, '0, SIZE_WORD));
        bus_ops.push_back(make_op(wdt_pkg::CMD_WRITE, wdt_pkg::OFS_CTRL | 12'h1, '0,
                                  wdt_pkg::SIZE_BYTE));
        bus_ops.push_back(make_op(wdt_pkg::CMD_WRITE, wdt_pkg::OFS_CTRL, 32'hFFFF_0002,
                                  wdt_pkg::SIZE_HALF));
        bus_ops.push_back(make_op(wdt_pkg::CMD_TICK, 12'hFFF, 32'hFFFF_FFFF, SIZE_WIDE));
        bus_ops.push_back(make_op(wdt_pkg::CMD_READ, wdt_pkg::OFS_RIS, '0, SIZE_WORD));
        bus_ops.push_back(make_op(wdt_pkg::CMD_WRITE, wdt_pkg::OFS_INTCLR, $urandom,
                                  SIZE_WORD));
        bus_ops.push_back(make_op(CMD_NONE, 12'hFFF, 32'hFFFF_FFFF, SIZE_WIDE));
        bus_ops.push_back(make_op(wdt_pkg::CMD_WRITE, wdt_pkg::OFS_LOAD | 12'h3,
                                  32'hFF00_0000, wdt_pkg::SIZE_BYTE));

        // queue no more operations until every response is back
        drain();
        repeat (475) bus_ops.push_back(random_op());
        drain();
        repeat (475) bus_ops.push_back(random_op());
        drain();
        repeat (TAIL_WAIT) @(posedge clk);

        if (fault_count == 0 && awaited_responses.size() == 0)
            $display("PASS watchdog_timer_registers_unit");
        else
            $display("FAIL watchdog_timer_registers_unit");
        $finish;
    end

endmodule
